/* hdl/scaled_decimal_compare_defines.svh */
// Assertion macros shared by the scaled decimal comparator RTL.
// Depends on i_clk and i_rst_n being visible where the macros are used.
`ifndef SCALED_DECIMAL_COMPARE_DEFINES_SVH
`define SCALED_DECIMAL_COMPARE_DEFINES_SVH

// Same-cycle implication, off while reset is held
`define SDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked a fixed number of edges later
`define SDC_ASSERT_LATER(label, ante, dly, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##(dly) (cons)) else $error(msg);

`endif

/* hdl/sdc_pkg.sv */
// Shared types and codes for the scaled decimal comparator.
// No dependencies; imported by every module of the block.
package sdc_pkg;

    localparam int unsigned SIG_W = 64;
    localparam int unsigned EXP_W = 32;

    typedef enum logic [1:0] {
        ORD_LESS    = 2'd0,
        ORD_EQUAL   = 2'd1,
        ORD_GREATER = 2'd2
    } t_order;

    // Control that travels with each beat down the cell chain
    typedef struct packed {
        logic valid;
        logic ovf;   // scaled side already known to exceed the other
        logic swap;  // operands were exchanged, mirror the final order
    } t_beat_ctl;

endpackage

/* hdl/sdc_front.sv */
// Front stage: aligns exponents and picks the side to be scaled.
// Depends on sdc_pkg.
module sdc_front #(
    parameter int unsigned POW_TABLE_SIZE = 20,
    parameter int unsigned CNT_W          = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [sdc_pkg::SIG_W-1:0] i_ls,
    input  logic [sdc_pkg::EXP_W-1:0] i_le,
    input  logic [sdc_pkg::SIG_W-1:0] i_rs,
    input  logic [sdc_pkg::EXP_W-1:0] i_re,
    output sdc_pkg::t_beat_ctl        o_ctl,
    output logic [sdc_pkg::SIG_W-1:0] o_s,
    output logic [sdc_pkg::SIG_W-1:0] o_t,
    output logic [CNT_W-1:0]          o_cnt
);
    import sdc_pkg::*;

    logic [EXP_W:0]   le_x, re_x, dr, dl, d;
    logic             exp_eq, le_lt, big, any_zero;
    t_beat_ctl        r_ctl, n_ctl;
    logic [SIG_W-1:0] r_s, n_s, r_t, n_t;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Take the exponent difference one bit wider so it never wraps
    always_comb begin
        le_x     = {i_le[EXP_W-1], i_le};
        re_x     = {i_re[EXP_W-1], i_re};
        dr       = re_x - le_x;
        dl       = le_x - re_x;
        exp_eq   = (i_le == i_re);
        le_lt    = ($signed(i_le) < $signed(i_re));
        d        = le_lt ? dr : dl;
        big      = (d >= (EXP_W+1)'(POW_TABLE_SIZE));
        any_zero = (i_ls == '0) || (i_rs == '0);
    end

    // Smaller-exponent side is s, the other side t gets scaled by ten d times
    always_comb begin
        n_ctl.valid = i_start;
        n_ctl.swap  = !le_lt;
        n_s         = le_lt ? i_ls : i_rs;
        n_t         = le_lt ? i_rs : i_ls;
        priority if (exp_eq || any_zero) begin
            n_ctl.ovf = 1'b0;
            n_cnt     = '0;
        end else if (big) begin
            n_ctl.ovf = 1'b1;
            n_cnt     = '0;
        end else begin
            n_ctl.ovf = 1'b0;
            n_cnt     = d[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s   <= n_s;
        r_t   <= n_t;
        r_cnt <= n_cnt;
    end

    assign o_ctl = r_ctl;
    assign o_s   = r_s;
    assign o_t   = r_t;
    assign o_cnt = r_cnt;

endmodule

/* hdl/sdc_cell.sv */
// One scaling cell: multiplies the scaled side by ten while its count runs.
// Depends on sdc_pkg.
module sdc_cell #(
    parameter int unsigned CNT_W = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sdc_pkg::t_beat_ctl        i_ctl,
    input  logic [sdc_pkg::SIG_W-1:0] i_s,
    input  logic [sdc_pkg::SIG_W-1:0] i_t,
    input  logic [CNT_W-1:0]          i_cnt,
    output sdc_pkg::t_beat_ctl        o_ctl,
    output logic [sdc_pkg::SIG_W-1:0] o_s,
    output logic [sdc_pkg::SIG_W-1:0] o_t,
    output logic [CNT_W-1:0]          o_cnt
);
    import sdc_pkg::*;

    logic [SIG_W+3:0] prod;
    logic             step;
    t_beat_ctl        r_ctl, n_ctl;
    logic [SIG_W-1:0] r_s, r_t, n_t;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // t * 10 as (t << 3) + (t << 1); anything above 64 bits beats s
    always_comb begin
        prod  = {1'b0, i_t, 3'b000} + {3'b000, i_t, 1'b0};
        step  = (i_cnt != '0) && !i_ctl.ovf;
        n_ctl = i_ctl;
        n_t   = i_t;
        n_cnt = i_cnt;
        if (step) begin
            n_cnt = i_cnt - CNT_W'(1);
            if (prod[SIG_W+3:SIG_W] != '0) begin
                n_ctl.ovf = 1'b1;
            end else begin
                n_t = prod[SIG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s   <= i_s;
        r_t   <= n_t;
        r_cnt <= n_cnt;
    end

    assign o_ctl = r_ctl;
    assign o_s   = r_s;
    assign o_t   = r_t;
    assign o_cnt = r_cnt;

endmodule

/* hdl/scaled_decimal_compare.sv */
// Scaled decimal comparator: orders two significand * 10^exponent values.
// Depends on sdc_pkg, sdc_front, sdc_cell and scaled_decimal_compare_defines.svh.
//
// Accepts one comparison in every clock cycle (busy is never raised) and
// delivers its order from the output register as a one-cycle o_valid beat;
// results leave in input order and cannot be stalled. Each beat crosses an
// exponent-alignment stage, a chain of POW_TABLE_SIZE - 1 multiply-by-ten
// cells that scale the larger-exponent significand, one decade per cell,
// and a compare stage at the end.
// o_order: 0 left less, 1 equal, 2 left greater.
`include "scaled_decimal_compare_defines.svh"

module scaled_decimal_compare #(
    parameter int unsigned POW_TABLE_SIZE = 20
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [sdc_pkg::SIG_W-1:0] i_left_significand,
    input  logic [sdc_pkg::EXP_W-1:0] i_left_exponent,
    input  logic [sdc_pkg::SIG_W-1:0] i_right_significand,
    input  logic [sdc_pkg::EXP_W-1:0] i_right_exponent,
    output logic                      o_valid,
    output logic [1:0]                o_order
);
    import sdc_pkg::*;

    localparam int unsigned NCELL = POW_TABLE_SIZE - 1;
    localparam int unsigned CNT_W = $clog2(POW_TABLE_SIZE);
    localparam int unsigned LAT   = NCELL + 2;

    t_beat_ctl        ctl [NCELL+1];
    logic [SIG_W-1:0] s   [NCELL+1];
    logic [SIG_W-1:0] t   [NCELL+1];
    logic [CNT_W-1:0] cnt [NCELL+1];

    t_order           raw_ord, n_ord;
    logic             r_valid;
    t_order           r_ord;
    logic             same_beat;

    assign busy = 1'b0;

    sdc_front #(
        .POW_TABLE_SIZE (POW_TABLE_SIZE),
        .CNT_W          (CNT_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_ls    (i_left_significand),
        .i_le    (i_left_exponent),
        .i_rs    (i_right_significand),
        .i_re    (i_right_exponent),
        .o_ctl   (ctl[0]),
        .o_s     (s[0]),
        .o_t     (t[0]),
        .o_cnt   (cnt[0])
    );

    // Chain of decade cells, one beat moves one cell per cycle
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        sdc_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl[k]),
            .i_s     (s[k]),
            .i_t     (t[k]),
            .i_cnt   (cnt[k]),
            .o_ctl   (ctl[k+1]),
            .o_s     (s[k+1]),
            .o_t     (t[k+1]),
            .o_cnt   (cnt[k+1])
        );
    end

    // Compare s against the scaled t, then mirror if the sides were swapped
    always_comb begin
        priority if (ctl[NCELL].ovf) begin
            raw_ord = ORD_LESS;
        end else if (s[NCELL] == t[NCELL]) begin
            raw_ord = ORD_EQUAL;
        end else if (s[NCELL] < t[NCELL]) begin
            raw_ord = ORD_LESS;
        end else begin
            raw_ord = ORD_GREATER;
        end
        n_ord = raw_ord;
        if (ctl[NCELL].swap) begin
            unique case (raw_ord)
                ORD_LESS:    n_ord = ORD_GREATER;
                ORD_GREATER: n_ord = ORD_LESS;
                ORD_EQUAL:   n_ord = ORD_EQUAL;
                default:     n_ord = ORD_EQUAL;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= ctl[NCELL].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ord <= n_ord;
    end

    assign o_valid = r_valid;
    assign o_order = r_ord;

    // Accepted beat whose two operands are identical
    assign same_beat = start && (i_left_significand == i_right_significand)
                       && (i_left_exponent == i_right_exponent);

    `SDC_ASSERT_NOW(a_order_code, o_valid, o_order <= ORD_GREATER, "order code out of range")
    `SDC_ASSERT_LATER(a_beat_out, start, LAT, o_valid, "accepted beat produced no result")
    `SDC_ASSERT_LATER(a_no_phantom, !start, LAT, !o_valid, "result without an accepted beat")
    `SDC_ASSERT_LATER(a_same_equal, same_beat, LAT, o_order == ORD_EQUAL, "same operands unequal")

endmodule
